[sv/plf_pkg.sv]
// Shared types and constants for the preamble/length bit framer.
`default_nettype none

package plf_pkg;

    localparam int STORE_DEPTH = 2048;
    localparam int STORE_AW    = 11;
    localparam int LEN_W       = 12;
    localparam int WORD_BITS   = 32;
    localparam int BYTE_BITS   = 8;

    localparam logic [4:0]  LAST_WORD_BIT  = 5'd31;
    localparam logic [2:0]  LAST_BYTE_BIT  = 3'd7;
    localparam logic [31:0] PREAMBLE_RESET = 32'hAAAA_AAAA;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_START = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        TXP_IDLE = 2'd0,
        TXP_PRE  = 2'd1,
        TXP_LEN  = 2'd2,
        TXP_DATA = 2'd3
    } tx_phase_t;

    typedef enum logic [1:0] {
        RXP_HUNT = 2'd0,
        RXP_LEN  = 2'd1,
        RXP_DATA = 2'd2
    } rx_phase_t;

    typedef struct packed {
        logic line;
        logic busy;
        logic done;
    } tx_status_t;

    typedef struct packed {
        logic                 byte_valid;
        logic [BYTE_BITS-1:0] rx_data;
        logic                 frame_end;
        logic                 length_error;
    } rx_result_t;

endpackage

`default_nettype wire

[sv/preamble_length_bit_framer_unit.sv]
// Top level of the preamble/length bit framer: command decode, config and result register.
//
// Each accepted input word (tick, write, start or spare) is handled in the cycle it is
// accepted and gives exactly one result word, held in the result register from the next
// cycle on; with out_ready high the block takes one word every cycle. The result register
// is the only stage, so a word is accepted whenever it is empty or being read out. The
// 2048-byte transmit store is a memory with one write and one registered read port; the
// next payload byte is prefetched while the current one is shifted out. The store is not
// cleared at reset: send only bytes that were written. Write the preamble only while idle.
`default_nettype none

module preamble_length_bit_framer_unit
    import plf_pkg::*;
#(
    parameter int MAX_LEN = 2048
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [WORD_BITS-1:0] cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           cmd,
    input  logic                 line_in,
    input  logic [STORE_AW-1:0]  buffer_addr,
    input  logic [BYTE_BITS-1:0] buffer_data,
    input  logic [LEN_W-1:0]     packet_length,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 line_out,
    output logic                 tx_busy,
    output logic                 tx_done,
    output logic                 rx_byte_valid,
    output logic [BYTE_BITS-1:0] rx_byte,
    output logic                 rx_frame_end,
    output logic                 rx_length_error
);

    logic [WORD_BITS-1:0] preamble_reg;
    logic                 out_valid_reg, out_valid_next;
    tx_status_t           tx_res_reg;
    rx_result_t           rx_res_reg;

    cmd_t       cmd_w;
    logic       accept;
    logic       tick;
    logic       wr_en;
    logic       start;
    tx_status_t tx_status;
    rx_result_t rx_result;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign cmd_w     = cmd_t'(cmd);

    always_comb
    begin
        tick  = 1'b0;
        wr_en = 1'b0;
        start = 1'b0;
        case (cmd_w)
            CMD_TICK:  tick  = accept;
            CMD_WRITE: wr_en = accept;
            CMD_START: start = accept;
            default:
            begin
                tick = 1'b0;
            end
        endcase
    end

    plf_tx u_tx (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick),
        .wr_en     (wr_en),
        .wr_addr   (buffer_addr),
        .wr_data   (buffer_data),
        .start     (start),
        .start_len (packet_length),
        .preamble  (preamble_reg),
        .status    (tx_status)
    );

    plf_rx #(
        .MAX_LEN (MAX_LEN)
    ) u_rx (
        .clk      (clk),
        .rst_n    (rst_n),
        .tick     (tick),
        .line_in  (line_in),
        .preamble (preamble_reg),
        .result   (rx_result)
    );

    assign out_valid_next = accept || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            preamble_reg  <= PREAMBLE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                preamble_reg <= cfg_data;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tx_res_reg <= tx_status;
            rx_res_reg <= rx_result;
        end
    end

    assign out_valid       = out_valid_reg;
    assign line_out        = tx_res_reg.line;
    assign tx_busy         = tx_res_reg.busy;
    assign tx_done         = tx_res_reg.done;
    assign rx_byte_valid   = rx_res_reg.byte_valid;
    assign rx_byte         = rx_res_reg.rx_data;
    assign rx_frame_end    = rx_res_reg.frame_end;
    assign rx_length_error = rx_res_reg.length_error;

endmodule

`default_nettype wire

[sv/plf_tx.sv]
// Transmit side: byte store, preamble/length/data serializer.
`default_nettype none

module plf_tx
    import plf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 tick,
    input  logic                 wr_en,
    input  logic [STORE_AW-1:0]  wr_addr,
    input  logic [BYTE_BITS-1:0] wr_data,
    input  logic                 start,
    input  logic [LEN_W-1:0]     start_len,
    input  logic [WORD_BITS-1:0] preamble,
    output tx_status_t           status
);

    tx_phase_t            phase_reg, phase_next;
    logic [4:0]           bit_cnt_reg, bit_cnt_next;
    logic [LEN_W-1:0]     byte_cnt_reg, byte_cnt_next;
    logic [LEN_W-1:0]     frame_len_reg, frame_len_next;
    logic                 line_reg, line_next;
    logic [BYTE_BITS-1:0] cur_byte_reg, cur_byte_next;
    logic [BYTE_BITS-1:0] rd_data_reg;
    logic [BYTE_BITS-1:0] store_mem [STORE_DEPTH];

    logic [STORE_AW-1:0]  rd_addr;
    logic [WORD_BITS-1:0] len_word;
    logic [LEN_W-1:0]     byte_cnt_inc;
    logic                 tx_bit;
    logic                 done_w;

    assign len_word     = WORD_BITS'(frame_len_reg);
    assign byte_cnt_inc = byte_cnt_reg + LEN_W'(1);

    // prefetch the byte after the one on the line; during the length field, byte 0
    assign rd_addr = (phase_reg == TXP_DATA) ? (byte_cnt_reg[STORE_AW-1:0] + STORE_AW'(1))
                                             : '0;

    always_ff @(posedge clk)
    begin
        if (wr_en && (phase_reg == TXP_IDLE))
        begin
            store_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= store_mem[rd_addr];
    end

    always_comb
    begin
        case (phase_reg)
            TXP_PRE:  tx_bit = preamble[bit_cnt_reg];
            TXP_LEN:  tx_bit = len_word[bit_cnt_reg];
            TXP_DATA: tx_bit = cur_byte_reg[bit_cnt_reg[2:0]];
            default:  tx_bit = line_reg;
        endcase
    end

    // next state
    always_comb
    begin
        phase_next     = phase_reg;
        bit_cnt_next   = bit_cnt_reg;
        byte_cnt_next  = byte_cnt_reg;
        frame_len_next = frame_len_reg;
        line_next      = line_reg;
        cur_byte_next  = cur_byte_reg;
        if (tick)
        begin
            case (phase_reg)
                TXP_PRE:
                begin
                    line_next = tx_bit;
                    if (bit_cnt_reg == LAST_WORD_BIT)
                    begin
                        bit_cnt_next = '0;
                        phase_next   = TXP_LEN;
                    end
                    else
                    begin
                        bit_cnt_next = bit_cnt_reg + 5'd1;
                    end
                end
                TXP_LEN:
                begin
                    line_next = tx_bit;
                    if (bit_cnt_reg == LAST_WORD_BIT)
                    begin
                        bit_cnt_next  = '0;
                        byte_cnt_next = '0;
                        if (frame_len_reg == '0)
                        begin
                            phase_next = TXP_IDLE;
                        end
                        else
                        begin
                            phase_next    = TXP_DATA;
                            cur_byte_next = rd_data_reg;
                        end
                    end
                    else
                    begin
                        bit_cnt_next = bit_cnt_reg + 5'd1;
                    end
                end
                TXP_DATA:
                begin
                    line_next = tx_bit;
                    if (bit_cnt_reg[2:0] == LAST_BYTE_BIT)
                    begin
                        bit_cnt_next = '0;
                        if (byte_cnt_inc >= frame_len_reg)
                        begin
                            phase_next    = TXP_IDLE;
                            byte_cnt_next = '0;
                        end
                        else
                        begin
                            byte_cnt_next = byte_cnt_inc;
                            cur_byte_next = rd_data_reg;
                        end
                    end
                    else
                    begin
                        bit_cnt_next = bit_cnt_reg + 5'd1;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (start && (phase_reg == TXP_IDLE) && (start_len <= LEN_W'(STORE_DEPTH)))
        begin
            frame_len_next = start_len;
            bit_cnt_next   = '0;
            byte_cnt_next  = '0;
            phase_next     = TXP_PRE;
        end
    end

    // outputs
    always_comb
    begin
        done_w = 1'b0;
        if (tick)
        begin
            case (phase_reg)
                TXP_LEN:  done_w = (bit_cnt_reg == LAST_WORD_BIT) && (frame_len_reg == '0);
                TXP_DATA: done_w = (bit_cnt_reg[2:0] == LAST_BYTE_BIT)
                                   && (byte_cnt_inc >= frame_len_reg);
                default:  done_w = 1'b0;
            endcase
        end
        status.line = line_next;
        status.busy = (phase_next != TXP_IDLE);
        status.done = done_w;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= TXP_IDLE;
            bit_cnt_reg   <= '0;
            byte_cnt_reg  <= '0;
            frame_len_reg <= '0;
            line_reg      <= 1'b1;
        end
        else
        begin
            phase_reg     <= phase_next;
            bit_cnt_reg   <= bit_cnt_next;
            byte_cnt_reg  <= byte_cnt_next;
            frame_len_reg <= frame_len_next;
            line_reg      <= line_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_byte_reg <= cur_byte_next;
    end

endmodule

`default_nettype wire

[sv/plf_rx.sv]
// Receive side: preamble hunt, length capture, byte assembly.
`default_nettype none

module plf_rx
    import plf_pkg::*;
#(
    parameter int MAX_LEN = 2048
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 tick,
    input  logic                 line_in,
    input  logic [WORD_BITS-1:0] preamble,
    output rx_result_t           result
);

    localparam int CNT_W = $clog2(MAX_LEN + 1);

    rx_phase_t            phase_reg, phase_next;
    logic [WORD_BITS-1:0] window_reg, window_next;
    logic [4:0]           bit_cnt_reg, bit_cnt_next;
    logic [CNT_W-1:0]     byte_cnt_reg, byte_cnt_next;
    logic [WORD_BITS-1:0] frame_len_reg, frame_len_next;
    logic [BYTE_BITS-1:0] asm_reg, asm_next;

    logic [WORD_BITS-1:0] window_shift;
    logic [WORD_BITS-1:0] len_acc;
    logic [BYTE_BITS-1:0] asm_acc;
    logic                 len_last;
    logic                 byte_last;
    logic                 len_too_big;
    logic                 frame_last;

    always_comb
    begin
        window_shift = {line_in, window_reg[WORD_BITS-1:1]};
        len_acc      = frame_len_reg;
        len_acc[bit_cnt_reg] = frame_len_reg[bit_cnt_reg] | line_in;
        asm_acc      = asm_reg;
        asm_acc[bit_cnt_reg[2:0]] = asm_reg[bit_cnt_reg[2:0]] | line_in;
        len_last     = (bit_cnt_reg == LAST_WORD_BIT);
        byte_last    = (bit_cnt_reg[2:0] == LAST_BYTE_BIT);
        len_too_big  = (len_acc > WORD_BITS'(MAX_LEN));
        frame_last   = ((WORD_BITS'(byte_cnt_reg) + WORD_BITS'(1)) >= frame_len_reg);
    end

    // next state
    always_comb
    begin
        phase_next     = phase_reg;
        window_next    = window_reg;
        bit_cnt_next   = bit_cnt_reg;
        byte_cnt_next  = byte_cnt_reg;
        frame_len_next = frame_len_reg;
        asm_next       = asm_reg;
        if (tick)
        begin
            case (phase_reg)
                RXP_HUNT:
                begin
                    if (window_shift == preamble)
                    begin
                        window_next    = '0;
                        phase_next     = RXP_LEN;
                        frame_len_next = '0;
                        bit_cnt_next   = '0;
                    end
                    else
                    begin
                        window_next = window_shift;
                    end
                end
                RXP_LEN:
                begin
                    frame_len_next = len_acc;
                    if (len_last)
                    begin
                        bit_cnt_next  = '0;
                        byte_cnt_next = '0;
                        asm_next      = '0;
                        if (len_too_big || (len_acc == '0))
                        begin
                            phase_next = RXP_HUNT;
                        end
                        else
                        begin
                            phase_next = RXP_DATA;
                        end
                    end
                    else
                    begin
                        bit_cnt_next = bit_cnt_reg + 5'd1;
                    end
                end
                RXP_DATA:
                begin
                    if (byte_last)
                    begin
                        bit_cnt_next = '0;
                        asm_next     = '0;
                        if (frame_last)
                        begin
                            byte_cnt_next = '0;
                            phase_next    = RXP_HUNT;
                        end
                        else
                        begin
                            byte_cnt_next = byte_cnt_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        asm_next     = asm_acc;
                        bit_cnt_next = bit_cnt_reg + 5'd1;
                    end
                end
                default:
                begin
                    phase_next = RXP_HUNT;
                end
            endcase
        end
    end

    // outputs
    always_comb
    begin
        result = '0;
        if (tick)
        begin
            case (phase_reg)
                RXP_LEN:
                begin
                    result.length_error = len_last && len_too_big;
                    result.frame_end    = len_last && (len_acc == '0);
                end
                RXP_DATA:
                begin
                    if (byte_last)
                    begin
                        result.byte_valid = 1'b1;
                        result.rx_data    = asm_acc;
                        result.frame_end  = frame_last;
                    end
                end
                default:
                begin
                    result = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= RXP_HUNT;
            window_reg    <= '0;
            bit_cnt_reg   <= '0;
            byte_cnt_reg  <= '0;
            frame_len_reg <= '0;
            asm_reg       <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            window_reg    <= window_next;
            bit_cnt_reg   <= bit_cnt_next;
            byte_cnt_reg  <= byte_cnt_next;
            frame_len_reg <= frame_len_next;
            asm_reg       <= asm_next;
        end
    end

endmodule

`default_nettype wire

[sv/plf_checker.sv]
// Port-level checks for the framer top level, with the bind that attaches them.
`default_nettype none

module plf_checker
    import plf_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic                 line_out,
    input logic                 tx_busy,
    input logic                 tx_done,
    input logic                 rx_byte_valid,
    input logic [BYTE_BITS-1:0] rx_byte,
    input logic                 rx_frame_end,
    input logic                 rx_length_error
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
            && $stable({line_out, tx_busy, tx_done, rx_byte_valid, rx_byte,
                        rx_frame_end, rx_length_error}))
        else $error("result word changed while stalled");

    // an empty result register never blocks the input side
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty result register");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && tx_done |-> !tx_busy)
        else $error("tx_done with transmitter still busy");

    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !rx_byte_valid |-> (rx_byte == '0))
        else $error("rx_byte nonzero without rx_byte_valid");

    a_err_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rx_length_error |-> !rx_byte_valid && !rx_frame_end)
        else $error("length error together with data or frame end");

endmodule

bind preamble_length_bit_framer_unit plf_checker u_plf_checker (.*);

`default_nettype wire

[test/testbench.sv]
// Self-checking testbench for the preamble/length bit framer: directed frames, then random traffic.
`timescale 1ns / 1ps

module testbench;
    import plf_pkg::*;

    localparam int         LEN_LIMIT = 2048;
    localparam int         FILL_BYTES = 40;
    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam int         RUN_LIMIT_NS = 100_000_000;

    typedef struct packed {
        tx_status_t tx;
        rx_result_t rx;
    } framer_result_t;

    class framer_scoreboard;
        logic [31:0]    preamble;
        tx_phase_t      tx_phase;
        int unsigned    tx_bit_idx;
        int unsigned    tx_byte_idx;
        logic [31:0]    tx_length;
        logic [7:0]     tx_store [STORE_DEPTH];
        logic           line_level;
        rx_phase_t      rx_phase;
        logic [31:0]    rx_window;
        logic [31:0]    rx_length;
        int unsigned    rx_bit_idx;
        int unsigned    rx_byte_idx;
        logic [7:0]     rx_assembly;
        framer_result_t expected_status [$];
        int             errors;

        function new();
            preamble    = PREAMBLE_RESET;
            tx_phase    = TXP_IDLE;
            tx_bit_idx  = 0;
            tx_byte_idx = 0;
            tx_length   = '0;
            line_level  = 1'b1;
            rx_phase    = RXP_HUNT;
            rx_window   = '0;
            rx_length   = '0;
            rx_bit_idx  = 0;
            rx_byte_idx = 0;
            rx_assembly = '0;
            errors      = 0;
            for (int i = 0; i < STORE_DEPTH; i++)
            begin
                tx_store[i] = '0;
            end
        endfunction

        function void load_preamble(logic [31:0] value);
            preamble = value;
        endfunction

        // Returns 1 on the bit that ends the frame.
        function bit shift_out_bit();
            bit   done;
            logic lvl;
            done = 1'b0;
            case (tx_phase)
                TXP_PRE:
                begin
                    lvl = preamble[tx_bit_idx];
                    tx_bit_idx++;
                    if (tx_bit_idx == WORD_BITS)
                    begin
                        tx_bit_idx = 0;
                        tx_phase   = TXP_LEN;
                    end
                end
                TXP_LEN:
                begin
                    lvl = tx_length[tx_bit_idx];
                    tx_bit_idx++;
                    if (tx_bit_idx == WORD_BITS)
                    begin
                        tx_bit_idx  = 0;
                        tx_byte_idx = 0;
                        if (tx_length == 0)
                        begin
                            tx_phase = TXP_IDLE;
                            done     = 1'b1;
                        end
                        else
                        begin
                            tx_phase = TXP_DATA;
                        end
                    end
                end
                TXP_DATA:
                begin
                    lvl = tx_store[tx_byte_idx % STORE_DEPTH][tx_bit_idx];
                    tx_bit_idx++;
                    if (tx_bit_idx == BYTE_BITS)
                    begin
                        tx_bit_idx = 0;
                        tx_byte_idx++;
                        if (tx_byte_idx >= tx_length)
                        begin
                            tx_phase    = TXP_IDLE;
                            tx_byte_idx = 0;
                            done        = 1'b1;
                        end
                    end
                end
                default:
                begin
                    return 1'b0;
                end
            endcase
            line_level = lvl;
            return done;
        endfunction

        function void shift_in_bit(logic b, inout rx_result_t rx);
            case (rx_phase)
                RXP_HUNT:
                begin
                    rx_window = {b, rx_window[31:1]};
                    if (rx_window == preamble)
                    begin
                        rx_window  = '0;
                        rx_phase   = RXP_LEN;
                        rx_length  = '0;
                        rx_bit_idx = 0;
                    end
                end
                RXP_LEN:
                begin
                    rx_length[rx_bit_idx] = b;
                    rx_bit_idx++;
                    if (rx_bit_idx == WORD_BITS)
                    begin
                        rx_bit_idx  = 0;
                        rx_byte_idx = 0;
                        rx_assembly = '0;
                        if (rx_length > LEN_LIMIT)
                        begin
                            rx.length_error = 1'b1;
                            rx_phase        = RXP_HUNT;
                        end
                        else if (rx_length == 0)
                        begin
                            rx.frame_end = 1'b1;
                            rx_phase     = RXP_HUNT;
                        end
                        else
                        begin
                            rx_phase = RXP_DATA;
                        end
                    end
                end
                default:
                begin
                    rx_assembly[rx_bit_idx] = b;
                    rx_bit_idx++;
                    if (rx_bit_idx == BYTE_BITS)
                    begin
                        rx_bit_idx    = 0;
                        rx.byte_valid = 1'b1;
                        rx.rx_data    = rx_assembly;
                        rx_assembly   = '0;
                        rx_byte_idx++;
                        if (rx_byte_idx >= rx_length)
                        begin
                            rx.frame_end = 1'b1;
                            rx_byte_idx  = 0;
                            rx_phase     = RXP_HUNT;
                        end
                    end
                end
            endcase
        endfunction

        function void note_word(logic [1:0] op, logic li, logic [STORE_AW-1:0] addr,
                                logic [BYTE_BITS-1:0] data, logic [LEN_W-1:0] plen);
            framer_result_t res;
            res = '0;
            if (op == CMD_TICK)
            begin
                res.tx.done = shift_out_bit();
                shift_in_bit(li, res.rx);
            end
            else if (op == CMD_WRITE)
            begin
                if (tx_phase == TXP_IDLE)
                    tx_store[addr] = data;
            end
            else if (op == CMD_START)
            begin
                if (tx_phase == TXP_IDLE && plen <= STORE_DEPTH)
                begin
                    tx_length   = 32'(plen);
                    tx_bit_idx  = 0;
                    tx_byte_idx = 0;
                    tx_phase    = TXP_PRE;
                end
            end
            res.tx.line = line_level;
            res.tx.busy = (tx_phase != TXP_IDLE);
            expected_status.push_back(res);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_word(framer_result_t got);
            framer_result_t want;
            if (expected_status.size() == 0)
            begin
                $error("result word with nothing pending");
                errors++;
                return;
            end
            want = expected_status.pop_front();
            compare_field("line_out", 32'(want.tx.line), 32'(got.tx.line));
            compare_field("tx_busy", 32'(want.tx.busy), 32'(got.tx.busy));
            compare_field("tx_done", 32'(want.tx.done), 32'(got.tx.done));
            compare_field("rx_byte_valid", 32'(want.rx.byte_valid), 32'(got.rx.byte_valid));
            compare_field("rx_byte", 32'(want.rx.rx_data), 32'(got.rx.rx_data));
            compare_field("rx_frame_end", 32'(want.rx.frame_end), 32'(got.rx.frame_end));
            compare_field("rx_length_error", 32'(want.rx.length_error),
                          32'(got.rx.length_error));
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n         = 1'b0;
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [WORD_BITS-1:0] cfg_data      = '0;
    logic                 in_valid      = 1'b0;
    logic                 in_ready;
    logic [1:0]           cmd           = CMD_TICK;
    logic                 line_in       = 1'b0;
    logic [STORE_AW-1:0]  buffer_addr   = '0;
    logic [BYTE_BITS-1:0] buffer_data   = '0;
    logic [LEN_W-1:0]     packet_length = '0;
    logic                 out_valid;
    logic                 out_ready     = 1'b0;
    logic                 line_out;
    logic                 tx_busy;
    logic                 tx_done;
    logic                 rx_byte_valid;
    logic [BYTE_BITS-1:0] rx_byte;
    logic                 rx_frame_end;
    logic                 rx_length_error;

    framer_scoreboard sb;
    bit               idling  = 1'b1;
    bit               auto_rx = 1'b0;
    bit               rx_plan [$];

    preamble_length_bit_framer_unit #(.MAX_LEN(LEN_LIMIT)) u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .line_in(line_in), .buffer_addr(buffer_addr),
        .buffer_data(buffer_data), .packet_length(packet_length),
        .out_valid(out_valid), .out_ready(out_ready),
        .line_out(line_out), .tx_busy(tx_busy), .tx_done(tx_done),
        .rx_byte_valid(rx_byte_valid), .rx_byte(rx_byte),
        .rx_frame_end(rx_frame_end), .rx_length_error(rx_length_error)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("FAILURE");
        $finish;
    end

    // Predict on accepted input words, check accepted result words.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.load_preamble(cfg_data);
            if (in_valid && in_ready)
                sb.note_word(cmd, line_in, buffer_addr, buffer_data, packet_length);
            if (out_valid && out_ready)
                sb.check_word({line_out, tx_busy, tx_done, rx_byte_valid, rx_byte,
                               rx_frame_end, rx_length_error});
        end
    end

    // Result side back-pressure.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (idling && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // Entered and left at a falling edge; valid stays high for a following word.
    task automatic push_word(logic [1:0] op, logic li, logic [STORE_AW-1:0] addr,
                             logic [BYTE_BITS-1:0] data, logic [LEN_W-1:0] plen);
        if (idling && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        in_valid      <= 1'b1;
        cmd           <= op;
        line_in       <= li;
        buffer_addr   <= addr;
        buffer_data   <= data;
        packet_length <= plen;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic queue_rx_frame(logic [31:0] len, int unsigned nbytes);
        for (int k = 0; k < WORD_BITS; k++)
            rx_plan.push_back(sb.preamble[k]);
        for (int k = 0; k < WORD_BITS; k++)
            rx_plan.push_back(len[k]);
        for (int k = 0; k < nbytes * BYTE_BITS; k++)
            rx_plan.push_back(1'($urandom_range(0, 1)));
    endtask

    // Mostly clean frames; some bad lengths, cut-off frames and line noise.
    task automatic plan_rx_traffic();
        int unsigned sel;
        int unsigned len;
        sel = $urandom_range(0, 99);
        if (sel < 70)
        begin
            len = $urandom_range(0, 6);
            queue_rx_frame(len, len);
        end
        else if (sel < 80)
        begin
            if ($urandom_range(0, 1) == 0)
                queue_rx_frame(LEN_LIMIT + 1 + $urandom_range(0, 1000), 0);
            else
                queue_rx_frame($urandom | 32'h8000_0000, 0);
        end
        else if (sel < 92)
        begin
            len = $urandom_range(1, 6);
            queue_rx_frame(len, $urandom_range(0, len - 1));
        end
        else
        begin
            repeat ($urandom_range(1, 40))
                rx_plan.push_back(1'($urandom_range(0, 1)));
        end
    endtask

    task automatic tick_once();
        bit b;
        if (rx_plan.size() == 0 && auto_rx && $urandom_range(0, 3) == 0)
            plan_rx_traffic();
        b = (rx_plan.size() != 0) ? rx_plan.pop_front() : 1'($urandom_range(0, 1));
        push_word(CMD_TICK, b, STORE_AW'($urandom), BYTE_BITS'($urandom), LEN_W'($urandom));
    endtask

    // Tick until both directions are back at rest.
    task automatic drain();
        while (rx_plan.size() != 0 || sb.tx_phase != TXP_IDLE || sb.rx_phase != RXP_HUNT)
            tick_once();
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (sb.expected_status.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_preamble(logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_items(int unsigned n);
        int unsigned      counted;
        int unsigned      pick;
        logic [LEN_W-1:0] plen;
        counted = 0;
        auto_rx = 1'b1;
        while (counted < n)
        begin
            pick = $urandom_range(0, 99);
            if (sb.tx_phase == TXP_IDLE && pick < 4)
            begin
                push_word(CMD_WRITE, 1'($urandom), STORE_AW'($urandom), BYTE_BITS'($urandom),
                          LEN_W'($urandom));
                counted++;
            end
            else if (sb.tx_phase == TXP_IDLE && pick < 10)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 14)
                    plen = LEN_W'($urandom_range(0, 8));
                else if (pick < 18)
                    plen = LEN_W'($urandom_range(9, FILL_BYTES));
                else
                    plen = LEN_W'($urandom_range(STORE_DEPTH + 1, 4095));
                push_word(CMD_START, 1'($urandom), STORE_AW'($urandom), BYTE_BITS'($urandom),
                          plen);
                if (plen <= STORE_DEPTH)
                    counted++;
            end
            else if (pick < 12)
            begin
                push_word(CMD_SPARE, 1'($urandom), STORE_AW'($urandom), BYTE_BITS'($urandom),
                          LEN_W'($urandom));
            end
            else if (pick < 15 && sb.tx_phase != TXP_IDLE)
            begin
                // dropped while a frame is on the line
                push_word(pick[0] ? CMD_WRITE : CMD_START, 1'($urandom), STORE_AW'($urandom),
                          BYTE_BITS'($urandom), LEN_W'($urandom));
            end
            else
            begin
                tick_once();
                counted++;
            end
        end
        auto_rx = 1'b0;
    endtask

    initial
    begin
        logic [31:0] next_preamble;
        sb = new();
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // fill the bytes that any accepted start below can send
        for (int a = 0; a < FILL_BYTES; a++)
            push_word(CMD_WRITE, 1'($urandom), STORE_AW'(a), BYTE_BITS'($urandom),
                      LEN_W'($urandom));

        push_word(CMD_SPARE, 1'b1, '1, '1, '1);
        push_word(CMD_START, 1'b0, '0, '0, '1);
        push_word(CMD_START, 1'b0, '0, '0, LEN_W'(STORE_DEPTH + 1));

        queue_rx_frame(0, 0);
        queue_rx_frame(1, 1);
        queue_rx_frame(LEN_LIMIT + 1, 0);
        queue_rx_frame(32'hFFFF_FFFF, 0);
        push_word(CMD_START, 1'b1, '0, '0, '0);
        repeat (3) tick_once();
        push_word(CMD_WRITE, 1'b0, '0, 8'h00, '0);
        push_word(CMD_START, 1'b0, '0, '0, LEN_W'(5));
        drain();

        push_word(CMD_WRITE, 1'b0, '0, 8'hFF, '0);
        push_word(CMD_WRITE, 1'b1, STORE_AW'(1), 8'h00, '0);
        push_word(CMD_START, 1'b0, '0, '0, LEN_W'(2));
        drain();

        for (int p = 0; p < 5; p++)
        begin
            drain();
            settle();
            case (p)
                0: next_preamble = 32'h0000_0000;
                1: next_preamble = 32'hFFFF_FFFF;
                4: next_preamble = PREAMBLE_RESET;
                default: next_preamble = $urandom;
            endcase
            write_preamble(next_preamble);
            idling = (p != 4);
            random_items(80);
        end

        in_valid <= 1'b0;
        while (sb.expected_status.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
